>>> hw/rtl/frame_format_checker_macros.svh
// ----------------------------------------------------------------------------
// Frame format checker assertion macros
// Shared assertion forms, clocked on i_clk and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef FRAME_FORMAT_CHECKER_MACROS_SVH
`define FRAME_FORMAT_CHECKER_MACROS_SVH

// Same-cycle implication
`define FFC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define FFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/fmchk_pkg.sv
// ----------------------------------------------------------------------------
// Frame format checker package
// Widths, status codes, register indexes, reset values and shared structs.
// ----------------------------------------------------------------------------
package fmchk_pkg;

    localparam int ByteW     = 8;
    localparam int SumW      = 16;
    localparam int CountW    = 9;
    localparam int LenW      = CountW + 1;
    localparam int WinDepth  = 5;
    localparam int LeadDepth = 4;
    localparam int LeadIdxW  = $clog2(LeadDepth);
    localparam int CfgIdxW   = 3;
    localparam int OutDataW  = 16;

    localparam int unsigned MaxFrameBytes = 255;
    localparam int unsigned MinFrameBytes = 9;

    // Register indexes
    localparam logic [CfgIdxW-1:0] CFG_HEADER_FIRST  = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_HEADER_SECOND = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_TAIL_FIRST    = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_TAIL_SECOND   = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_TAIL_THIRD    = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_NODE_ADDRESS  = 3'd5;

    // Register reset values
    localparam logic [ByteW-1:0] RST_HEADER_FIRST  = 8'h59;
    localparam logic [ByteW-1:0] RST_HEADER_SECOND = 8'hA6;
    localparam logic [ByteW-1:0] RST_TAIL_FIRST    = 8'h59;
    localparam logic [ByteW-1:0] RST_TAIL_SECOND   = 8'h48;
    localparam logic [ByteW-1:0] RST_TAIL_THIRD    = 8'h54;
    localparam logic [ByteW-1:0] RST_NODE_ADDRESS  = 8'h01;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_HEADER   = 3'd1,
        ST_TAIL     = 3'd2,
        ST_LENGTH   = 3'd3,
        ST_CHECKSUM = 3'd4,
        ST_ADDRESS  = 3'd5
    } t_status;

    typedef struct packed {
        logic [ByteW-1:0] header_first;
        logic [ByteW-1:0] header_second;
        logic [ByteW-1:0] tail_first;
        logic [ByteW-1:0] tail_second;
        logic [ByteW-1:0] tail_third;
        logic [ByteW-1:0] node_address;
    } t_cfg;

    // Per-frame running state
    typedef struct packed {
        logic [SumW-1:0]                 sum;
        logic [CountW-1:0]               count;
        logic [WinDepth-1:0][ByteW-1:0]  win;
        logic [LeadDepth-1:0][ByteW-1:0] lead;
    } t_frame;

    // Evaluation results for the byte in flight
    typedef struct packed {
        logic [SumW-1:0]  sum_nx;
        t_status          status;
        logic [ByteW-1:0] frame_bytes;
    } t_eval;

endpackage

>>> hw/rtl/fmchk_eval.sv
// ----------------------------------------------------------------------------
// Frame format checker evaluation
// Updates the checksum for the byte in flight and ranks the frame checks.
// ----------------------------------------------------------------------------
module fmchk_eval (
    input  fmchk_pkg::t_cfg                i_cfg,
    input  fmchk_pkg::t_frame              i_frame,
    input  logic [fmchk_pkg::ByteW-1:0]    i_byte,
    output fmchk_pkg::t_eval               o_eval
);

    logic [fmchk_pkg::SumW-1:0] sum_nx;
    logic [fmchk_pkg::LenW-1:0] len;
    logic                       len_bad;
    logic                       hdr_bad;
    logic                       tail_bad;
    logic                       lbyte_bad;
    logic                       csum_bad;
    logic                       addr_bad;
    fmchk_pkg::t_status         status;

    // Oldest window byte joins the sum once the window has filled
    always_comb begin
        if (i_frame.count >= fmchk_pkg::CountW'(fmchk_pkg::WinDepth)) begin
            sum_nx = i_frame.sum + fmchk_pkg::SumW'(i_frame.win[fmchk_pkg::WinDepth-1]);
        end else begin
            sum_nx = i_frame.sum;
        end
    end

    assign len = fmchk_pkg::LenW'(i_frame.count) + fmchk_pkg::LenW'(1);

    // Individual checks
    assign len_bad   = (len < fmchk_pkg::LenW'(fmchk_pkg::MinFrameBytes)) ||
                       (len > fmchk_pkg::LenW'(fmchk_pkg::MaxFrameBytes));
    assign hdr_bad   = (i_frame.lead[0] != i_cfg.header_first) ||
                       (i_frame.lead[1] != i_cfg.header_second);
    assign tail_bad  = (i_frame.win[1] != i_cfg.tail_first) ||
                       (i_frame.win[0] != i_cfg.tail_second) ||
                       (i_byte != i_cfg.tail_third);
    assign lbyte_bad = (fmchk_pkg::LenW'(i_frame.lead[2]) != len);
    assign csum_bad  = (i_frame.win[3] != sum_nx[15:8]) ||
                       (i_frame.win[2] != sum_nx[7:0]);
    assign addr_bad  = (i_frame.lead[3] != i_cfg.node_address);

    // Status by priority
    always_comb begin
        priority if (len_bad) begin
            status = fmchk_pkg::ST_LENGTH;
        end else if (hdr_bad) begin
            status = fmchk_pkg::ST_HEADER;
        end else if (tail_bad) begin
            status = fmchk_pkg::ST_TAIL;
        end else if (lbyte_bad) begin
            status = fmchk_pkg::ST_LENGTH;
        end else if (csum_bad) begin
            status = fmchk_pkg::ST_CHECKSUM;
        end else if (addr_bad) begin
            status = fmchk_pkg::ST_ADDRESS;
        end else begin
            status = fmchk_pkg::ST_OK;
        end
    end

    assign o_eval.sum_nx      = sum_nx;
    assign o_eval.status      = status;
    assign o_eval.frame_bytes = (len > fmchk_pkg::LenW'(8'hFF)) ? 8'hFF
                                                                : len[fmchk_pkg::ByteW-1:0];

endmodule

>>> hw/rtl/frame_format_checker.sv
// ----------------------------------------------------------------------------
// Frame format checker
// Checks header, tail, length byte, additive checksum and node address of a
// byte-wide received frame and reports one status word per frame.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle; the input register feeds the check logic.
// Status: the result register takes it when the last byte leaves the input register.
// A last byte waits in the input register while a previous status is unread.
// Reset (i_rst_n low, synchronous): frame state cleared, registers loaded with
// their defaults, both pipeline stages emptied.
`include "frame_format_checker_macros.svh"

module frame_format_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration write port
    input  logic                                 i_cfg_we,
    input  logic [fmchk_pkg::CfgIdxW-1:0]        i_cfg_idx,
    input  logic [fmchk_pkg::ByteW-1:0]          i_cfg_wdata,
    // Byte stream in
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [fmchk_pkg::ByteW-1:0]          s_tdata,   // [7:0] rx_byte
    input  logic                                 s_tlast,   // frame_end
    // Status out
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [fmchk_pkg::OutDataW-1:0]       m_tdata    // [2:0] check_status,
                                                            // [10:3] frame_bytes,
                                                            // [15:11] zero
);

    fmchk_pkg::t_cfg   r_cfg;
    fmchk_pkg::t_frame frame;
    fmchk_pkg::t_eval  eval;

    logic                                                  r_in_vld;
    logic [fmchk_pkg::ByteW-1:0]                           r_in_byte;
    logic                                                  r_in_last;
    logic [fmchk_pkg::SumW-1:0]                            r_sum;
    logic [fmchk_pkg::CountW-1:0]                          r_cnt;
    logic [fmchk_pkg::WinDepth-1:0][fmchk_pkg::ByteW-1:0]  r_win;
    logic [fmchk_pkg::LeadDepth-1:0][fmchk_pkg::ByteW-1:0] r_lead;
    logic                                                  r_out_vld;
    fmchk_pkg::t_status                                    r_out_status;
    logic [fmchk_pkg::ByteW-1:0]                           r_out_bytes;

    logic [fmchk_pkg::SumW-1:0]                            n_sum;
    logic [fmchk_pkg::CountW-1:0]                          n_cnt;
    logic                                                  out_free;
    logic                                                  adv;
    logic                                                  close;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_first  <= fmchk_pkg::RST_HEADER_FIRST;
            r_cfg.header_second <= fmchk_pkg::RST_HEADER_SECOND;
            r_cfg.tail_first    <= fmchk_pkg::RST_TAIL_FIRST;
            r_cfg.tail_second   <= fmchk_pkg::RST_TAIL_SECOND;
            r_cfg.tail_third    <= fmchk_pkg::RST_TAIL_THIRD;
            r_cfg.node_address  <= fmchk_pkg::RST_NODE_ADDRESS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fmchk_pkg::CFG_HEADER_FIRST:  r_cfg.header_first  <= i_cfg_wdata;
                fmchk_pkg::CFG_HEADER_SECOND: r_cfg.header_second <= i_cfg_wdata;
                fmchk_pkg::CFG_TAIL_FIRST:    r_cfg.tail_first    <= i_cfg_wdata;
                fmchk_pkg::CFG_TAIL_SECOND:   r_cfg.tail_second   <= i_cfg_wdata;
                fmchk_pkg::CFG_TAIL_THIRD:    r_cfg.tail_third    <= i_cfg_wdata;
                fmchk_pkg::CFG_NODE_ADDRESS:  r_cfg.node_address  <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Pipeline flow: non-last bytes never need the output slot
    assign out_free = !r_out_vld || m_tready;
    assign adv      = r_in_vld && (!r_in_last || out_free);
    assign close    = adv && r_in_last;
    assign s_tready = !r_in_vld || adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_tready) begin
            r_in_vld <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_in_byte <= s_tdata;
            r_in_last <= s_tlast;
        end
    end

    // Frame checks
    assign frame.sum   = r_sum;
    assign frame.count = r_cnt;
    assign frame.win   = r_win;
    assign frame.lead  = r_lead;

    fmchk_eval u_eval (
        .i_cfg   (r_cfg),
        .i_frame (frame),
        .i_byte  (r_in_byte),
        .o_eval  (eval)
    );

    // Next sum and count; both clear when the frame closes
    always_comb begin
        n_sum = r_sum;
        n_cnt = r_cnt;
        if (adv) begin
            if (r_in_last) begin
                n_sum = '0;
                n_cnt = '0;
            end else begin
                n_sum = eval.sum_nx;
                if (r_cnt != '1) begin
                    n_cnt = r_cnt + fmchk_pkg::CountW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else begin
            r_sum <= n_sum;
            r_cnt <= n_cnt;
        end
    end

    // Delay line and leading bytes; always rewritten before they matter
    always_ff @(posedge i_clk) begin
        if (adv && !r_in_last) begin
            r_win <= {r_win[fmchk_pkg::WinDepth-2:0], r_in_byte};
            if (r_cnt < fmchk_pkg::CountW'(fmchk_pkg::LeadDepth)) begin
                r_lead[r_cnt[fmchk_pkg::LeadIdxW-1:0]] <= r_in_byte;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (close) begin
            r_out_vld <= 1'b1;
        end else if (m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (close) begin
            r_out_status <= eval.status;
            r_out_bytes  <= eval.frame_bytes;
        end
    end

    assign m_tvalid = r_out_vld;
    assign m_tdata  = {5'b0, r_out_bytes, r_out_status};

    // Checks
    `FFC_ASSERT_NEXT(a_close_gives_result, close, m_tvalid, "frame close lost its status")
    `FFC_ASSERT_NEXT(a_close_clears_state, close, (r_cnt == '0) && (r_sum == '0),
        "frame state not cleared after close")
    `FFC_ASSERT_NOW(a_ok_len_in_range, m_tvalid && (r_out_status == fmchk_pkg::ST_OK),
        r_out_bytes >= 8'(fmchk_pkg::MinFrameBytes), "ok status on a short frame")

endmodule
